// File: src/fdrq_pkg.sv
// ----------------------------------------------------------------------------
// fdrq_pkg - shared types and constants of the datagram receive queue
// Ring geometry, operation and status codes, register indexes and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package fdrq_pkg;

	// ring geometry
	localparam int unsigned RING_SLOTS = 8;
	localparam int unsigned SLOT_BYTES = 2048;

	localparam int unsigned SLOT_W  = $clog2(RING_SLOTS);
	localparam int unsigned SUM_W   = SLOT_W + 1;
	localparam int unsigned CNT_W   = $clog2(RING_SLOTS + 1);
	localparam int unsigned OFF_W   = $clog2(SLOT_BYTES + 1);
	localparam int unsigned ADDR_W  = $clog2(RING_SLOTS * SLOT_BYTES);
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned RAM_DEPTH = RING_SLOTS * SLOT_BYTES;

	// item operations
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// configuration register indexes
	localparam logic REG_PEER_ADDR = 1'b0;
	localparam logic REG_PEER_PORT = 1'b1;

	typedef enum logic [2:0] {
		ST_BYTE     = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_POP_NONE = 3'd2,
		ST_STORED   = 3'd3,
		ST_STRANGER = 3'd4,
		ST_FULL     = 3'd5,
		ST_TRUNC    = 3'd6
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_LOAD
	} ctl_state_t;

	// take: a transaction is accepted this cycle; load: result register loads
	typedef struct packed {
		logic take;
		logic load;
	} fdrq_cmd_t;

endpackage

// File: src/filtered_datagram_receive_queue.sv
// ----------------------------------------------------------------------------
// filtered_datagram_receive_queue - receive ring for one connected peer
// Controller and datapath around a single-port payload RAM.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one transaction per byte. operation receive brings a datagram
//           byte with its source; operation read takes one byte of the
//           head datagram (read_limit caps the bytes handed out).
//   out_* : exactly one result transaction per input transaction, in order.
//   cfg_* : peer address (index 0) and peer port (index 1); cfg_ready is
//           always high. Write only while no transaction is in flight.
// Timing
//   An accepted transaction updates the ring at once and issues its RAM
//   access; the result register loads on the following cycle, when the
//   registered read data of the payload RAM is there. No new transaction
//   is taken until that result has loaded.
// Reset and stalls
//   arst_n empties the ring and clears counters and peer registers; no
//   clearing pass, the block is ready right after reset. While a result
//   is presented and out_ready is low, it is held and in_ready stays low.
// ----------------------------------------------------------------------------
module filtered_datagram_receive_queue
	import fdrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] src_addr,
	input  logic [15:0] source_port,
	input  logic [7:0]  data_byte,
	input  logic        end_of_datagram,
	input  logic [15:0] read_limit,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  read_byte,
	output logic        last_read,
	output logic [3:0]  queued,
	output logic [31:0] stranger_drops,
	output logic [31:0] full_drops,
	output logic [31:0] delivered_total
);

	fdrq_cmd_t cmd;

	// configuration never stalls
	assign cfg_ready = 1'b1;

	fdrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fdrq_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.src_addr        (src_addr),
		.source_port     (source_port),
		.data_byte       (data_byte),
		.end_of_datagram (end_of_datagram),
		.read_limit      (read_limit),
		.status          (status),
		.read_byte       (read_byte),
		.last_read       (last_read),
		.queued          (queued),
		.stranger_drops  (stranger_drops),
		.full_drops      (full_drops),
		.delivered_total (delivered_total)
	);

`ifndef SYNTH
	// a transaction in flight blocks the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	// result follows acceptance once the result register has loaded
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##1 out_valid)
		else $error("result not presented after accepted transaction");

	// only a byte read carries data or the last-byte mark
	a_byte_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_BYTE)) |-> ((read_byte == 8'd0) && !last_read))
		else $error("read data on a result that is not a byte read");

	// ring occupancy bounded
	a_queued_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queued <= 4'(RING_SLOTS)))
		else $error("queued exceeds ring size");
`endif

endmodule

// File: src/fdrq_ram.sv
// ----------------------------------------------------------------------------
// fdrq_ram - generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fdrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/fdrq_ctrl.sv
// ----------------------------------------------------------------------------
// fdrq_ctrl - sequencing of the datagram receive queue
// Two-state controller: accept a transaction, then load the result register.
// ----------------------------------------------------------------------------
module fdrq_ctrl
	import fdrq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output fdrq_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = CS_LOAD;
				end
			end
			CS_LOAD: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.take = in_valid && in_ready;
			end
			CS_LOAD: begin
				cmd.load = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/fdrq_dpath.sv
// ----------------------------------------------------------------------------
// fdrq_dpath - datapath of the datagram receive queue
// Peer registers, ring pointers, reception and read state, drop counters,
// payload RAM, length table and the result register.
// ----------------------------------------------------------------------------
module fdrq_dpath
	import fdrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fdrq_cmd_t   cmd,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        operation,
	input  logic [31:0] src_addr,
	input  logic [15:0] source_port,
	input  logic [7:0]  data_byte,
	input  logic        end_of_datagram,
	input  logic [15:0] read_limit,
	output logic [2:0]  status,
	output logic [7:0]  read_byte,
	output logic        last_read,
	output logic [3:0]  queued,
	output logic [31:0] stranger_drops,
	output logic [31:0] full_drops,
	output logic [31:0] delivered_total
);

	// configuration
	logic [31:0] peer_addr_q;
	logic [15:0] peer_port_q;

	// ring and reception state
	logic [SLOT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              rx_busy_q, rx_busy_d;
	logic              rx_acc_q, rx_acc_d;
	logic              rx_dropfull_q, rx_dropfull_d;
	logic [SLOT_W-1:0] rx_slot_q, rx_slot_d;
	logic [OFF_W-1:0]  rx_off_q, rx_off_d;
	logic [OFF_W-1:0]  rd_off_q, rd_off_d;
	logic [31:0]       strangers_q, strangers_d;
	logic [31:0]       fulls_q, fulls_d;
	logic [31:0]       delivered_q, delivered_d;

	// committed lengths, one per slot
	logic [OFF_W-1:0]  len_q [RING_SLOTS];
	logic              len_we;

	// per-transaction result, held until the result register loads
	status_t           status_q, status_d;
	logic              last_q, last_d;

	// result register
	logic [2:0]        status_o_q;
	logic [7:0]        read_byte_o_q;
	logic              last_o_q;
	logic [3:0]        queued_o_q;
	logic [31:0]       strangers_o_q;
	logic [31:0]       fulls_o_q;
	logic [31:0]       delivered_o_q;

	// working signals
	logic               peer_match;
	logic               acc_e;
	logic               dropfull_e;
	logic [SLOT_W-1:0]  slot_e;
	logic [OFF_W-1:0]   off_e;
	logic [OFF_W-1:0]   off_n;
	logic [SUM_W-1:0]   tail_sum;
	logic [SLOT_W-1:0]  tail_slot;
	logic [LIMIT_W-1:0] have_w;
	logic [LIMIT_W-1:0] n_w;
	logic [LIMIT_W-1:0] rd_ext;
	logic [LIMIT_W-1:0] rd_next;
	logic               do_pop;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [7:0]         ram_rdata;

	assign peer_match = (src_addr == peer_addr_q) && (source_port == peer_port_q);

	// next free slot behind the committed ones
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_slot = (tail_sum >= SUM_W'(RING_SLOTS)) ?
		SLOT_W'(tail_sum - SUM_W'(RING_SLOTS)) : SLOT_W'(tail_sum);

	assign have_w  = LIMIT_W'(len_q[head_q]);
	assign n_w     = (read_limit < have_w) ? read_limit : have_w;
	assign rd_ext  = LIMIT_W'(rd_off_q);
	assign rd_next = rd_ext + LIMIT_W'(1);

	always_comb begin
		head_d        = head_q;
		count_d       = count_q;
		rx_busy_d     = rx_busy_q;
		rx_acc_d      = rx_acc_q;
		rx_dropfull_d = rx_dropfull_q;
		rx_slot_d     = rx_slot_q;
		rx_off_d      = rx_off_q;
		rd_off_d      = rd_off_q;
		strangers_d   = strangers_q;
		fulls_d       = fulls_q;
		delivered_d   = delivered_q;
		status_d      = status_q;
		last_d        = last_q;
		len_we        = 1'b0;
		ram_we        = 1'b0;
		acc_e         = rx_acc_q;
		dropfull_e    = rx_dropfull_q;
		slot_e        = rx_slot_q;
		off_e         = rx_off_q;
		off_n         = rx_off_q;
		do_pop        = 1'b0;
		ram_addr      = ADDR_W'(head_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_off_q);

		if (cmd.take) begin
			last_d = 1'b0;
			if (operation == OP_RECEIVE) begin
				// first byte: source filter and ring space decide the datagram
				if (!rx_busy_q) begin
					off_e = '0;
					if (!peer_match) begin
						strangers_d = strangers_q + 32'd1;
						acc_e       = 1'b0;
						dropfull_e  = 1'b0;
					end else if (count_q >= CNT_W'(RING_SLOTS)) begin
						fulls_d    = fulls_q + 32'd1;
						acc_e      = 1'b0;
						dropfull_e = 1'b1;
					end else begin
						acc_e  = 1'b1;
						slot_e = tail_slot;
					end
				end
				off_n    = off_e;
				ram_addr = ADDR_W'(slot_e) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off_e);
				if (!acc_e) begin
					status_d = dropfull_e ? ST_FULL : ST_STRANGER;
				end else if (off_e < OFF_W'(SLOT_BYTES)) begin
					ram_we   = 1'b1;
					off_n    = off_e + OFF_W'(1);
					status_d = ST_STORED;
				end else begin
					status_d = ST_TRUNC;
				end
				rx_slot_d     = slot_e;
				rx_dropfull_d = dropfull_e;
				if (end_of_datagram) begin
					if (acc_e && (count_q < CNT_W'(RING_SLOTS))) begin
						len_we  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
					rx_busy_d = 1'b0;
					rx_acc_d  = 1'b0;
					rx_off_d  = '0;
				end else begin
					rx_busy_d = 1'b1;
					rx_acc_d  = acc_e;
					rx_off_d  = off_n;
				end
			end else begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if ((n_w == '0) || (rd_ext >= n_w)) begin
					do_pop   = 1'b1;
					status_d = ST_POP_NONE;
				end else begin
					status_d = ST_BYTE;
					if (rd_next >= n_w) begin
						last_d = 1'b1;
						do_pop = 1'b1;
					end else begin
						rd_off_d = OFF_W'(rd_next);
					end
				end
				if (do_pop) begin
					head_d      = (head_q == SLOT_W'(RING_SLOTS - 1)) ?
						'0 : head_q + SLOT_W'(1);
					count_d     = count_q - CNT_W'(1);
					rd_off_d    = '0;
					delivered_d = delivered_q + 32'd1;
				end
			end
		end
	end

	fdrq_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (data_byte),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_addr_q   <= '0;
			peer_port_q   <= '0;
			head_q        <= '0;
			count_q       <= '0;
			rx_busy_q     <= 1'b0;
			rx_acc_q      <= 1'b0;
			rx_dropfull_q <= 1'b0;
			rx_slot_q     <= '0;
			rx_off_q      <= '0;
			rd_off_q      <= '0;
			strangers_q   <= '0;
			fulls_q       <= '0;
			delivered_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PEER_ADDR: peer_addr_q <= cfg_data;
					REG_PEER_PORT: peer_port_q <= cfg_data[15:0];
					default:       peer_addr_q <= peer_addr_q;
				endcase
			end
			head_q        <= head_d;
			count_q       <= count_d;
			rx_busy_q     <= rx_busy_d;
			rx_acc_q      <= rx_acc_d;
			rx_dropfull_q <= rx_dropfull_d;
			rx_slot_q     <= rx_slot_d;
			rx_off_q      <= rx_off_d;
			rd_off_q      <= rd_off_d;
			strangers_q   <= strangers_d;
			fulls_q       <= fulls_d;
			delivered_q   <= delivered_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		status_q <= status_d;
		last_q   <= last_d;
		if (len_we) begin
			len_q[slot_e] <= off_n;
		end
		if (cmd.load) begin
			status_o_q    <= status_q;
			read_byte_o_q <= (status_q == ST_BYTE) ? ram_rdata : 8'd0;
			last_o_q      <= last_q;
			queued_o_q    <= 4'(count_q);
			strangers_o_q <= strangers_q;
			fulls_o_q     <= fulls_q;
			delivered_o_q <= delivered_q;
		end
	end

	assign status          = status_o_q;
	assign read_byte       = read_byte_o_q;
	assign last_read       = last_o_q;
	assign queued          = queued_o_q;
	assign stranger_drops  = strangers_o_q;
	assign full_drops      = fulls_o_q;
	assign delivered_total = delivered_o_q;

endmodule
